@@ hdl/bia_pkg.sv @@
`default_nettype none
package bia_pkg;

   // Pool size and the widths fixed by the beat fields.
   localparam int NUM_IDS   = 256;
   localparam int ID_W      = 8;
   localparam int MAX_W     = 9;
   localparam int STATUS_W  = 2;
   localparam int ID_SPAN   = 1 << ID_W;

   // Only ids that fit the 8-bit fields are ever mapped.
   localparam int MAP_IDS   = (NUM_IDS < ID_SPAN) ? NUM_IDS : ID_SPAN;

   // The bitmap is held as words of 64 flags, one word scanned per read.
   localparam int WORD_W    = 64;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int NUM_WORDS = (MAP_IDS + WORD_W - 1) / WORD_W;
   localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int VISIT_W   = $clog2(NUM_WORDS + 1);

   localparam logic [MAX_W-1:0] MAX_IDS_RESET = MAX_W'(256);
   localparam logic [MAX_W-1:0] MAP_LIMIT     = MAX_W'(MAP_IDS);

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic eval;
      logic step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic rsp_free;
   } dp_sts_type;

endpackage
`default_nettype wire

@@ hdl/bia_ram.sv @@
`default_nettype none
module bia_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  wire logic                                     clock,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic                                     we,
   input  wire logic                                     re,
   input  wire logic [WIDTH-1:0]                         wdata,
   output logic      [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ hdl/bia_ctrl.sv @@
`default_nettype none
module bia_ctrl
   import bia_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ:   state_in = S_EVAL;
         S_EVAL: begin
            state_in = sts.done ? S_FINISH : S_READ;
         end
         S_FINISH: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_READ: begin
            cmd.read = 1'b1;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            cmd.step = !sts.done;
         end
         S_FINISH: begin
            cmd.finish = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/bia_datapath.sv @@
`default_nettype none
module bia_datapath
   import bia_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_sts_type               sts,
   input  wire logic                req_mode,
   input  wire logic [ID_W-1:0]     req_start_id,
   input  wire logic [ID_W-1:0]     req_free_id,
   input  wire logic                csr_valid,
   input  wire logic [MAX_W-1:0]    csr_max_ids,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic      [ID_W-1:0]     rsp_alloc_id,
   output logic      [STATUS_W-1:0] rsp_status
);

   logic [MAX_W-1:0]    max_ids_ff;
   logic [MAX_W-1:0]    lim;

   logic                mode_ff,  mode_in;
   logic [ID_W-1:0]     start_ff, start_in;
   logic [ID_W-1:0]     fid_ff;
   logic                range_ok_ff, range_ok_in;
   logic [WIDX_W-1:0]   word_ff,  word_in;
   logic [VISIT_W-1:0]  visit_ff, visit_in;
   logic [NUM_WORDS-1:0] row_valid_ff;
   logic                rd_valid_ff;

   logic [WORD_W-1:0]   ram_q;
   logic [WORD_W-1:0]   word_bits;
   logic [WORD_W-1:0]   cand;
   logic [WORD_W-1:0]   wdata;
   logic                ram_we;
   logic                found;
   logic                last_visit;
   logic [BIT_W-1:0]    hit_bit;
   logic [MAX_W-1:0]    bit_id;

   logic [ID_W-1:0]     res_id_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                rsp_valid_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ids_ff <= MAX_IDS_RESET;
      end else if (csr_valid) begin
         max_ids_ff <= csr_max_ids;
      end
   end

   assign lim = (max_ids_ff > MAP_LIMIT) ? MAP_LIMIT : max_ids_ff;

   // Capture the request; a start outside the active range searches from zero.
   always_comb begin
      mode_in     = req_mode;
      range_ok_in = MAX_W'(req_free_id) < lim;
      start_in    = (MAX_W'(req_start_id) < lim) ? req_start_id : '0;
      visit_in    = '0;
      if (req_mode == MODE_FREE) begin
         word_in = range_ok_in ? WIDX_W'(req_free_id >> BIT_W) : '0;
      end else begin
         word_in = WIDX_W'(start_in >> BIT_W);
      end
      if (!cmd.load) begin
         mode_in     = mode_ff;
         range_ok_in = range_ok_ff;
         start_in    = start_ff;
         visit_in    = visit_ff;
         word_in     = word_ff;
         if (cmd.step) begin
            visit_in = visit_ff + VISIT_W'(1);
            word_in  = (word_ff == WIDX_W'(NUM_WORDS - 1)) ? '0 : word_ff + WIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      start_ff    <= start_in;
      range_ok_ff <= range_ok_in;
      word_ff     <= word_in;
      visit_ff    <= visit_in;
      if (cmd.load) begin
         fid_ff <= req_free_id;
      end
   end

   // A word never written since reset reads as all free.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.read) begin
            rd_valid_ff <= row_valid_ff[word_ff];
         end
         if (ram_we) begin
            row_valid_ff[word_ff] <= 1'b1;
         end
      end
   end

   assign word_bits  = rd_valid_ff ? ram_q : '0;
   assign last_visit = (visit_ff == VISIT_W'(NUM_WORDS));

   // The first visit of the start word covers ids at or above start, the
   // closing visit of the same word covers the ids below it.
   always_comb begin
      cand = '0;
      for (int b = 0; b < WORD_W; b++) begin
         bit_id  = MAX_W'({word_ff, BIT_W'(b)});
         cand[b] = !word_bits[b] && (bit_id < lim);
         if (visit_ff == '0) begin
            cand[b] = cand[b] && (bit_id >= MAX_W'(start_ff));
         end else if (last_visit) begin
            cand[b] = cand[b] && (bit_id < MAX_W'(start_ff));
         end
      end
   end

   always_comb begin
      hit_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (cand[b]) hit_bit = BIT_W'(b);
      end
   end

   assign found = |cand;

   always_comb begin
      if (mode_ff == MODE_FREE) begin
         wdata  = word_bits & ~(WORD_W'(1) << fid_ff[BIT_W-1:0]);
         ram_we = cmd.eval && range_ok_ff;
      end else begin
         wdata  = word_bits | (WORD_W'(1) << hit_bit);
         ram_we = cmd.eval && found;
      end
   end

   bia_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_WORDS)
   ) u_map (
      .clock (clock),
      .addr  (word_ff),
      .we    (ram_we),
      .re    (cmd.read),
      .wdata (wdata),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         if (mode_ff == MODE_FREE) begin
            res_id_ff     <= '0;
            res_status_ff <= range_ok_ff ? STATUS_DONE : STATUS_RANGE;
         end else if (found) begin
            res_id_ff     <= ID_W'({word_ff, hit_bit});
            res_status_ff <= STATUS_DONE;
         end else begin
            res_id_ff     <= '0;
            res_status_ff <= STATUS_FULL;
         end
      end
   end

   assign sts.done     = (mode_ff == MODE_FREE) || found || last_visit;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_id_ff     <= res_id_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_alloc_id = rsp_id_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
`default_nettype wire

@@ hdl/bitmap_id_allocator_unit.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_mode, req_start_id, req_free_id
// rsp       out        rsp_valid / rsp_ready  rsp_alloc_id, rsp_status
// csr       in         csr_valid / csr_ready  csr_max_ids
//
// The result beat is offered once the request beat is accepted, the first word is read
// and evaluated, and the result is moved into the output register when it is free; an
// allocation that misses reads and evaluates each further 64-id word in turn. The map
// memory is read once per visited word, at most NUM_WORDS + 1 visits; a free visits one.
// Synchronous active-high reset clears the map through per-word valid flags.
// A new request is taken while a finished result waits in the output register.
`default_nettype none
module bitmap_id_allocator_unit
   import bia_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_mode,
   input  wire logic [ID_W-1:0]     req_start_id,
   input  wire logic [ID_W-1:0]     req_free_id,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [ID_W-1:0]     rsp_alloc_id,
   output logic      [STATUS_W-1:0] rsp_status,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [MAX_W-1:0]    csr_max_ids
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   assign csr_ready = 1'b1;

   bia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bia_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_mode     (req_mode),
      .req_start_id (req_start_id),
      .req_free_id  (req_free_id),
      .csr_valid    (csr_valid),
      .csr_max_ids  (csr_max_ids),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_alloc_id (rsp_alloc_id),
      .rsp_status   (rsp_status)
   );

endmodule
`default_nettype wire

@@ hdl/bia_checker.sv @@
`default_nettype none
module bia_checker
   import bia_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_mode,
   input wire logic [ID_W-1:0]     req_start_id,
   input wire logic [ID_W-1:0]     req_free_id,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [ID_W-1:0]     rsp_alloc_id,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic                csr_valid,
   input wire logic                csr_ready,
   input wire logic [MAX_W-1:0]    csr_max_ids
);

   // The block works on one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_alloc_id) && $stable(rsp_status)))
      else $error("stalled result beat changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_DONE || rsp_status == STATUS_FULL ||
                     rsp_status == STATUS_RANGE))
      else $error("undefined status code");

   a_id_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_DONE) |-> (rsp_alloc_id == '0))
      else $error("nonzero id on a failed request");

endmodule

bind bitmap_id_allocator_unit bia_checker u_bia_checker (.*);
`default_nettype wire

@@ tb/id_pool_checker.sv @@
module id_pool_checker
   import bia_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic                req_mode,
   input  wire logic [ID_W-1:0]     req_start_id,
   input  wire logic [ID_W-1:0]     req_free_id,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic [ID_W-1:0]     rsp_alloc_id,
   input  wire logic [STATUS_W-1:0] rsp_status,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [MAX_W-1:0]    csr_max_ids,
   output int                       mismatch_count,
   output int                       pending_grants
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ID_W-1:0]     alloc_id;
      logic [STATUS_W-1:0] status;
   } id_reply_type;

   logic [MAP_IDS-1:0] id_in_use;
   logic [MAX_W-1:0]   pool_size;
   id_reply_type       expected_grants[$];
   int                 errors = 0;

   task automatic note_mismatch(input string what);
      $display("[%0t] id pool mismatch: %s", $time, what);
      errors++;
   endtask

   // Applies one request beat to the shadow pool and returns the reply it should get.
   function automatic id_reply_type grant_for(input logic mode,
                                              input logic [ID_W-1:0] start_id,
                                              input logic [ID_W-1:0] free_id);
      id_reply_type reply;
      int           limit;
      int           first;
      int           found;
      int           probe;
      reply.alloc_id = '0;
      reply.status   = STATUS_DONE;
      limit = (pool_size < MAP_LIMIT) ? int'(pool_size) : int'(MAP_LIMIT);
      if (mode == MODE_FREE) begin
         if (int'(free_id) < limit) begin
            id_in_use[free_id] = 1'b0;
         end else begin
            reply.status = STATUS_RANGE;
         end
         return reply;
      end
      first = (int'(start_id) < limit) ? int'(start_id) : 0;
      found = -1;
      // Walking from the start id modulo the limit visits the upper range first,
      // then wraps to the lower one, lowest id first in each.
      for (int n = 0; n < limit; n++) begin
         probe = (first + n) % limit;
         if (found < 0 && !id_in_use[probe]) begin
            found = probe;
         end
      end
      if (found < 0) begin
         reply.status = STATUS_FULL;
      end else begin
         id_in_use[found] = 1'b1;
         reply.alloc_id   = ID_W'(found);
      end
      return reply;
   endfunction

   always @(posedge clock) begin : watch
      id_reply_type want;
      if (reset) begin
         id_in_use = '0;
         pool_size = MAX_IDS_RESET;
         expected_grants.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            pool_size = csr_max_ids;
         end
         // Responses are matched before the new request is queued, so a stray
         // response can never pair with a request taken on the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               note_mismatch($sformatf("response beat id %0d status %0d with none expected",
                                       rsp_alloc_id, rsp_status));
            end else begin
               want = expected_grants.pop_front();
               if (rsp_alloc_id !== want.alloc_id) begin
                  note_mismatch($sformatf("alloc_id got %0d expected %0d",
                                          rsp_alloc_id, want.alloc_id));
               end
               if (rsp_status !== want.status) begin
                  note_mismatch($sformatf("status got %0d expected %0d",
                                          rsp_status, want.status));
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_grants.push_back(grant_for(req_mode, req_start_id, req_free_id));
         end
      end
      mismatch_count <= errors;
      pending_grants <= expected_grants.size();
   end

endmodule

@@ tb/bitmap_id_allocator_unit_tb.sv @@
module bitmap_id_allocator_unit_tb;
   import bia_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 24;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_mode = MODE_ALLOC;
   logic [ID_W-1:0]     req_start_id = '0;
   logic [ID_W-1:0]     req_free_id = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ID_W-1:0]     rsp_alloc_id;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [MAX_W-1:0]    csr_max_ids = '0;
   int                  mismatch_count;
   int                  pending_grants;
   int                  beats_sent = 0;

   bitmap_id_allocator_unit u_top (.*);

   id_pool_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offers one request beat; valid stays up into the next beat when no gap is drawn.
   task automatic push_req(input logic mode, input logic [ID_W-1:0] start_id,
                           input logic [ID_W-1:0] free_id);
      int gap;
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_start_id <= start_id;
      req_free_id  <= free_id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      gap = ((beats_sent / 50) % 4 == 3) ? 0 : $urandom_range(16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_grants != 0) @(posedge clock);
   endtask

   task automatic write_max_ids(input logic [MAX_W-1:0] value);
      drain();
      csr_valid   <= 1'b1;
      csr_max_ids <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int pool, input int count, input int alloc_pct);
      int              limit;
      logic            mode;
      logic [ID_W-1:0] start_id;
      logic [ID_W-1:0] free_id;
      write_max_ids(MAX_W'(pool));
      limit = (pool < MAP_IDS) ? pool : MAP_IDS;
      for (int k = 0; k < count; k++) begin
         mode = ($urandom_range(99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
         // Mostly ids inside the pool, now and then anything the field holds.
         if (limit != 0 && $urandom_range(9) < 8) begin
            start_id = ID_W'($urandom_range(limit - 1));
            free_id  = ID_W'($urandom_range(limit - 1));
         end else begin
            start_id = ID_W'($urandom);
            free_id  = ID_W'($urandom);
         end
         push_req(mode, start_id, free_id);
      end
      drain();
   endtask

   // Receiver: random stalls, quiet stretches, and two long hold-offs that back
   // the block up into its request channel.
   initial begin : receiver
      int stall;
      int taken;
      taken = 0;
      forever begin
         if (taken == 150 || taken == 600) begin
            stall = LONG_HOLD;
         end else if ((taken / 40) % 3 == 2) begin
            stall = 0;
         end else begin
            stall = $urandom_range(16);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("** bitmap_id_allocator_unit: FAILED **");
      $finish;
   end

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Full pool from reset: both ends of the id range and the wrap.
      push_req(MODE_ALLOC, 8'd0, 8'd0);
      push_req(MODE_ALLOC, 8'd255, 8'd0);
      push_req(MODE_ALLOC, 8'd255, 8'd0);
      push_req(MODE_FREE, 8'd0, 8'd0);
      push_req(MODE_FREE, 8'd0, 8'd0);
      push_req(MODE_FREE, 8'd0, 8'd255);
      push_req(MODE_ALLOC, 8'd200, 8'd0);

      // A tiny pool: fill it, hit full, free out of range, start beyond the limit.
      write_max_ids(9'd4);
      push_req(MODE_ALLOC, 8'd0, 8'd0);
      push_req(MODE_ALLOC, 8'd0, 8'd0);
      push_req(MODE_ALLOC, 8'd3, 8'd0);
      push_req(MODE_ALLOC, 8'd2, 8'd0);
      push_req(MODE_ALLOC, 8'd1, 8'd0);
      push_req(MODE_FREE, 8'd0, 8'd9);
      push_req(MODE_FREE, 8'd0, 8'd3);
      push_req(MODE_ALLOC, 8'd9, 8'd0);

      write_max_ids(9'd0);
      push_req(MODE_ALLOC, 8'd0, 8'd0);
      push_req(MODE_FREE, 8'd0, 8'd0);

      // Raising the limit again brings back the ids taken before it was lowered.
      write_max_ids(9'd511);
      push_req(MODE_ALLOC, 8'd255, 8'd255);
      push_req(MODE_FREE, 8'd0, 8'd255);
      push_req(MODE_ALLOC, 8'd170, 8'd85);

      write_max_ids(9'd1);
      push_req(MODE_ALLOC, 8'd0, 8'd0);
      push_req(MODE_FREE, 8'd0, 8'd0);
      push_req(MODE_ALLOC, 8'd128, 8'd0);
      push_req(MODE_ALLOC, 8'd0, 8'd1);

      run_phase(256, 320, 85);
      run_phase(64, 100, 60);
      run_phase(1, 40, 50);
      run_phase(8, 80, 55);
      run_phase(511, 100, 50);
      run_phase(130, 100, 60);
      run_phase(0, 20, 50);
      run_phase(200, 100, 50);
      run_phase(256, 60, 40);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** bitmap_id_allocator_unit: PASSED **");
      end else begin
         $display("** bitmap_id_allocator_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ bitmap_id_allocator_unit.f @@
hdl/bia_pkg.sv
hdl/bia_ram.sv
hdl/bia_ctrl.sv
hdl/bia_datapath.sv
hdl/bitmap_id_allocator_unit.sv
hdl/bia_checker.sv
tb/id_pool_checker.sv
tb/bitmap_id_allocator_unit_tb.sv
